// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the front, queue and back rtl files
// both expect clk and rst_n in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define RHFP_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in one cycle implies a condition in the next
`define RHFP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/rhfp_pkg.sv =====
`default_nettype none

package rhfp_pkg;

  // result kinds
  localparam logic [3:0] KIND_MODE    = 4'd0;
  localparam logic [3:0] KIND_VERSION = 4'd1;
  localparam logic [3:0] KIND_LEN     = 4'd2;
  localparam logic [3:0] KIND_BYTE    = 4'd3;
  localparam logic [3:0] KIND_SCORE   = 4'd4;
  localparam logic [3:0] KIND_PERFECT = 4'd5;
  localparam logic [3:0] KIND_MODS    = 4'd6;
  localparam logic [3:0] KIND_TIME    = 4'd7;
  localparam logic [3:0] KIND_BAD     = 4'd8;

  // header format constants
  localparam logic [7:0] STR_INDICATOR = 8'h0b;
  localparam logic [7:0] GROUP_MASK    = 8'h7f;
  localparam logic [7:0] MORE_BIT      = 8'h80;
  localparam logic [3:0] SKIP_BYTES    = 4'd12;
  localparam logic [3:0] NUM_BYTES_32  = 4'd4;
  localparam logic [3:0] NUM_BYTES_64  = 4'd8;
  localparam logic [6:0] GROUP_BITS    = 7'd7;

  // what the back end does with a command word
  typedef enum logic {
    CMD_EMIT   = 1'b0,  // value is complete, send it out
    CMD_GATHER = 1'b1   // little-endian byte to merge at lane
  } cmd_op_t;

  // command word from front to back
  typedef struct packed {
    cmd_op_t     op;
    logic [3:0]  kind;
    logic [1:0]  snum;
    logic        last;
    logic [2:0]  lane;
    logic [63:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/replay_header_field_parser.sv =====
// channel  ports                                         handshake
// -------  --------------------------------------------  ---------------------------
// input    in_data_byte, in_restart                      in_push / in_full
// result   out_field_kind, out_string_number,            out_pop / out_empty
//          out_field_value
//
// one byte a cycle in while in_full is low; the front parser settles each byte in the cycle it is taken
// a result passes through the command queue and then the registered result slot
// the command queue (FIFO_DEPTH words) lets front and back stall apart
// in_full rises only once the queue is full behind a stalled result slot
// reset is synchronous; it empties queue and result slot and restarts at the mode field
`default_nettype none

module replay_header_field_parser #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_restart,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [3:0]       out_field_kind,
  output logic [1:0]       out_string_number,
  output logic [63:0]      out_field_value
);

  logic           q_full, cmd_push, cmd_valid, cmd_pop;
  rhfp_pkg::cmd_t cmd_in, cmd_head;

  assign in_full = q_full;

  // parser
  rhfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_restart   (in_restart),
    .q_full_i     (q_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  // command queue
  rhfp_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (cmd_push),
    .push_cmd_i (cmd_in),
    .full_o     (q_full),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .head_o     (cmd_head)
  );

  // value assembly and result slot
  rhfp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd_head),
    .cmd_pop_o         (cmd_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_field_kind    (out_field_kind),
    .out_string_number (out_string_number),
    .out_field_value   (out_field_value)
  );

endmodule

`default_nettype wire

// ===== rtl/rhfp_front.sv =====
`default_nettype none

module rhfp_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_restart,
  input  wire logic          q_full_i,
  output logic               cmd_push_o,
  output rhfp_pkg::cmd_t     cmd_o
);

  `include "assert_macros.svh"

  // field sequence
  typedef enum logic [11:0] {
    ST_MODE    = 12'b0000_0000_0001,
    ST_VERSION = 12'b0000_0000_0010,
    ST_STR0    = 12'b0000_0000_0100,
    ST_STR1    = 12'b0000_0000_1000,
    ST_STR2    = 12'b0000_0001_0000,
    ST_SKIP    = 12'b0000_0010_0000,
    ST_SCORE   = 12'b0000_0100_0000,
    ST_PERFECT = 12'b0000_1000_0000,
    ST_MODS    = 12'b0001_0000_0000,
    ST_STR3    = 12'b0010_0000_0000,
    ST_TIME    = 12'b0100_0000_0000,
    ST_DONE    = 12'b1000_0000_0000
  } step_t;

  // phases within a string
  typedef enum logic [2:0] {
    PH_IND     = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  step_t       step_r, step_nxt, step_cur;
  phase_t      phase_r, phase_nxt, phase_cur;
  logic [3:0]  bcnt_r, bcnt_nxt, bcnt_cur, bcnt_inc;
  logic [63:0] len_r, len_nxt, len_cur, len_full, grp;
  logic [6:0]  shift_r, shift_nxt, shift_cur;
  logic [63:0] rem_r, rem_nxt, rem_cur, rem_dec;
  logic        accept, adv;
  logic [1:0]  snum;
  logic [3:0]  nbytes;
  logic [3:0]  nkind;

  assign accept = in_push && !q_full_i;

  // string number and numeric field shape for the current step
  always_comb begin
    snum   = 2'd0;
    nbytes = rhfp_pkg::NUM_BYTES_32;
    nkind  = rhfp_pkg::KIND_VERSION;
    case (step_cur)
      ST_STR1:  snum = 2'd1;
      ST_STR2:  snum = 2'd2;
      ST_STR3:  snum = 2'd3;
      ST_SCORE: nkind = rhfp_pkg::KIND_SCORE;
      ST_MODS:  nkind = rhfp_pkg::KIND_MODS;
      ST_TIME: begin
        nkind  = rhfp_pkg::KIND_TIME;
        nbytes = rhfp_pkg::NUM_BYTES_64;
      end
      default: ;
    endcase
  end

  // parse one byte
  always_comb begin
    step_cur  = in_restart ? ST_MODE : step_r;
    phase_cur = in_restart ? PH_IND : phase_r;
    bcnt_cur  = in_restart ? 4'd0 : bcnt_r;
    len_cur   = in_restart ? 64'd0 : len_r;
    shift_cur = in_restart ? 7'd0 : shift_r;
    rem_cur   = in_restart ? 64'd0 : rem_r;

    step_nxt  = step_cur;
    phase_nxt = phase_cur;
    bcnt_nxt  = bcnt_cur;
    len_nxt   = len_cur;
    shift_nxt = shift_cur;
    rem_nxt   = rem_cur;

    bcnt_inc = bcnt_cur + 4'd1;
    grp      = shift_cur[6] ? 64'd0 :
               ({56'd0, in_data_byte & rhfp_pkg::GROUP_MASK} << shift_cur[5:0]);
    len_full = len_cur | grp;
    rem_dec  = rem_cur - 64'd1;

    adv        = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o      = '{op: rhfp_pkg::CMD_EMIT, kind: rhfp_pkg::KIND_MODE, snum: 2'd0,
                   last: 1'b1, lane: 3'd0, value: {56'd0, in_data_byte}};

    case (step_cur)
      ST_MODE: begin
        cmd_push_o = 1'b1;
        adv        = 1'b1;
      end
      ST_PERFECT: begin
        cmd_o.kind = rhfp_pkg::KIND_PERFECT;
        cmd_push_o = 1'b1;
        adv        = 1'b1;
      end
      ST_VERSION, ST_SCORE, ST_MODS, ST_TIME: begin
        cmd_o.op   = rhfp_pkg::CMD_GATHER;
        cmd_o.kind = nkind;
        cmd_o.lane = bcnt_cur[2:0];
        cmd_o.last = (bcnt_inc >= nbytes);
        cmd_push_o = 1'b1;
        bcnt_nxt   = bcnt_inc;
        adv        = (bcnt_inc >= nbytes);
      end
      ST_SKIP: begin
        bcnt_nxt = bcnt_inc;
        adv      = (bcnt_inc >= rhfp_pkg::SKIP_BYTES);
      end
      ST_STR0, ST_STR1, ST_STR2, ST_STR3: begin
        cmd_o.snum = snum;
        case (phase_cur)
          PH_IND: begin
            if (in_data_byte != rhfp_pkg::STR_INDICATOR) begin
              cmd_o.kind  = rhfp_pkg::KIND_BAD;
              cmd_o.value = 64'd0;
              cmd_push_o  = 1'b1;
              adv         = 1'b1;
            end else begin
              phase_nxt = PH_LENGTH;
              len_nxt   = 64'd0;
              shift_nxt = 7'd0;
            end
          end
          PH_LENGTH: begin
            if ((in_data_byte & rhfp_pkg::MORE_BIT) != 8'd0) begin
              len_nxt = len_full;
              if (!shift_cur[6]) begin
                shift_nxt = shift_cur + rhfp_pkg::GROUP_BITS;
              end
            end else begin
              cmd_o.kind  = rhfp_pkg::KIND_LEN;
              cmd_o.value = len_full;
              cmd_push_o  = 1'b1;
              if (len_full == 64'd0) begin
                adv = 1'b1;
              end else begin
                rem_nxt   = len_full;
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            cmd_o.kind = rhfp_pkg::KIND_BYTE;
            cmd_push_o = 1'b1;
            rem_nxt    = rem_dec;
            adv        = (rem_dec == 64'd0);
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // move on to the following field
    if (adv) begin
      case (step_cur)
        ST_MODE:    step_nxt = ST_VERSION;
        ST_VERSION: step_nxt = ST_STR0;
        ST_STR0:    step_nxt = ST_STR1;
        ST_STR1:    step_nxt = ST_STR2;
        ST_STR2:    step_nxt = ST_SKIP;
        ST_SKIP:    step_nxt = ST_SCORE;
        ST_SCORE:   step_nxt = ST_PERFECT;
        ST_PERFECT: step_nxt = ST_MODS;
        ST_MODS:    step_nxt = ST_STR3;
        ST_STR3:    step_nxt = ST_TIME;
        default:    step_nxt = ST_DONE;
      endcase
      phase_nxt = PH_IND;
      bcnt_nxt  = 4'd0;
      len_nxt   = 64'd0;
      shift_nxt = 7'd0;
      rem_nxt   = 64'd0;
    end

    // nothing moves without an accepted word
    if (!accept) begin
      step_nxt   = step_r;
      phase_nxt  = phase_r;
      bcnt_nxt   = bcnt_r;
      len_nxt    = len_r;
      shift_nxt  = shift_r;
      rem_nxt    = rem_r;
      cmd_push_o = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_MODE;
      phase_r <= PH_IND;
      bcnt_r  <= 4'd0;
      len_r   <= 64'd0;
      shift_r <= 7'd0;
      rem_r   <= 64'd0;
    end else begin
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      len_r   <= len_nxt;
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // payload phase always has bytes left to take
  `RHFP_ASSERT(a_front_payload_left, (phase_r != PH_PAYLOAD) || (rem_r != 64'd0), "payload phase with zero remaining")

endmodule

`default_nettype wire

// ===== rtl/rhfp_queue.sv =====
`default_nettype none

module rhfp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_i,
  input  wire rhfp_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output rhfp_pkg::cmd_t     head_o
);

  `include "assert_macros.svh"

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rhfp_pkg::cmd_t mem_r [DEPTH];
  logic [IW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == CW'(DEPTH));
  assign valid_o = (cnt_r != '0);
  assign head_o  = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + IW'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + IW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_cmd_i;
    end
  end

  `RHFP_ASSERT(a_queue_no_overflow, !(push_i && full_o), "command pushed into full queue")
  `RHFP_ASSERT(a_queue_no_underflow, !(pop_i && !valid_o), "command popped from empty queue")

endmodule

`default_nettype wire

// ===== rtl/rhfp_back.sv =====
`default_nettype none

module rhfp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid_i,
  input  wire rhfp_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_empty,
  input  wire logic           out_pop,
  output logic [3:0]          out_field_kind,
  output logic [1:0]          out_string_number,
  output logic [63:0]         out_field_value
);

  `include "assert_macros.svh"

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_kind_r;
  logic [1:0]  out_snum_r;
  logic [63:0] out_value_r;
  logic [63:0] gath_r, gathered, base;
  logic        slot_free, produces, take;

  // merge the byte into its little-endian lane, lane zero starts afresh
  assign base     = (cmd_i.lane == 3'd0) ? 64'd0 : gath_r;
  assign gathered = base | ({56'd0, cmd_i.value[7:0]} << {cmd_i.lane, 3'b000});

  assign slot_free = !out_valid_r || out_pop;
  assign produces  = (cmd_i.op == rhfp_pkg::CMD_EMIT) || cmd_i.last;
  assign take      = cmd_valid_i && (slot_free || !produces);
  assign cmd_pop_o = take;

  // result slot handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (take && produces) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload and partial value
  always_ff @(posedge clk) begin
    if (take) begin
      if (produces) begin
        out_kind_r  <= cmd_i.kind;
        out_snum_r  <= cmd_i.snum;
        out_value_r <= (cmd_i.op == rhfp_pkg::CMD_EMIT) ? cmd_i.value : gathered;
      end else begin
        gath_r <= gathered;
      end
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_field_kind    = out_kind_r;
  assign out_string_number = out_snum_r;
  assign out_field_value   = out_value_r;

  // a finishing command shows up on the result slot next cycle
  `RHFP_ASSERT_NEXT(a_back_emit, take && produces, out_valid_r && (out_kind_r == $past(cmd_i.kind)), "finished command missing from result slot")

endmodule

`default_nettype wire
